### hw/rtl/iol_pkg.sv
// Package for the indexed ordered list: default sizes, command and status codes,
// and the sequencer state encoding.
// No dependencies.
`default_nettype none

package iol_pkg;

  // Default sizes
  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned VALUE_BITS_DEF = 32;

  // Command codes carried by an input beat
  typedef enum logic [2:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_INSERT     = 3'd4,
    CMD_ERASE      = 3'd5,
    CMD_DUMP       = 3'd6,
    CMD_NONE       = 3'd7
  } cmd_t;

  // Status codes carried by a result beat
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_BAD_POS = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // Sequencer states, one-hot
  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_INS     = 7'b0000010,
    S_INS_WR  = 7'b0000100,
    S_ERS     = 7'b0001000,
    S_ERS_WR  = 7'b0010000,
    S_DMP_RD  = 7'b0100000,
    S_DMP_OUT = 7'b1000000
  } state_t;

endpackage

`default_nettype wire

### hw/rtl/iol_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module iol_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/indexed_ordered_list.sv
// Indexed ordered list: bounded sequence with push/pop at both ends, indexed
// insert/erase and dump. Depends on iol_pkg and iol_ram.
// A rejected command (empty, bad position, full) strobes its status in the next
// cycle and never raises busy; code 7 gives no beat. Insert holds busy while it
// shifts the entries from the position up, a read and a write each, then writes the
// value; erase likewise pulls later entries down (push back and pop back move none). The
// status beat comes in the cycle busy drops. Dump holds busy while it reads each
// element and sends its beat, the last with busy low. Receiver cannot stall: out_valid
// is a one-cycle strobe. Reset (rst_n low, synchronous) empties the list, not the RAM.
`default_nettype none

module indexed_ordered_list #(
  parameter int unsigned DEPTH      = iol_pkg::DEPTH_DEF,
  parameter int unsigned VALUE_BITS = iol_pkg::VALUE_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // command channel
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         in_command,
  input  wire logic [7:0]         in_position,
  input  wire logic signed [31:0] in_value,
  // result channel
  output logic                    out_valid,
  output logic signed [31:0]      out_elem_out,
  output logic                    out_has_value,
  output logic [1:0]              out_status,
  output logic                    out_last
);

  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned LEN_W  = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W  = (LEN_W > 8) ? LEN_W : 8;

  // Sequencer and list state
  iol_pkg::state_t        state_r, state_nxt;
  logic [LEN_W-1:0]       length_r, length_nxt;
  logic [ADDR_W-1:0]      idx_r, idx_nxt;
  logic [ADDR_W-1:0]      pos_r, pos_nxt;
  logic [VALUE_BITS-1:0]  val_r, val_nxt;

  // Result registers
  logic                   out_valid_r, out_valid_nxt;
  logic signed [31:0]     out_elem_r, out_elem_nxt;
  logic                   out_has_r, out_has_nxt;
  iol_pkg::status_t       out_status_r, out_status_nxt;
  logic                   out_last_r, out_last_nxt;

  // RAM port
  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [VALUE_BITS-1:0]  ram_wdata;
  logic [ADDR_W-1:0]      ram_raddr;
  logic [VALUE_BITS-1:0]  ram_rdata;

  logic [VALUE_BITS-1:0]  in_val_kept;
  logic signed [31:0]     rd_elem;
  logic                   full, empty;
  logic [CMP_W-1:0]       pos_cmp, len_cmp;
  logic [LEN_W-1:0]       idx_ext_inc;
  iol_pkg::cmd_t          cmd;

  iol_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Keep low VALUE_BITS of the input; widen stored values back to 32 bits
  assign in_val_kept = VALUE_BITS'($unsigned(in_value));

  generate
    if (VALUE_BITS >= 32) begin : g_wide
      assign rd_elem = ram_rdata[31:0];
    end else begin : g_narrow
      assign rd_elem = 32'(signed'(ram_rdata));
    end
  endgenerate

  assign cmd         = iol_pkg::cmd_t'(in_command);
  assign full        = (length_r == LEN_W'(DEPTH));
  assign empty       = (length_r == '0);
  assign pos_cmp     = CMP_W'(in_position);
  assign len_cmp     = CMP_W'(length_r);
  assign idx_ext_inc = LEN_W'(idx_r) + LEN_W'(1);

  assign busy = (state_r != iol_pkg::S_IDLE);

  // Sequencer: decode in idle, then move one element per read/write pair
  always_comb begin
    state_nxt      = state_r;
    length_nxt     = length_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    out_valid_nxt  = 1'b0;
    out_elem_nxt   = '0;
    out_has_nxt    = 1'b0;
    out_status_nxt = iol_pkg::ST_OK;
    out_last_nxt   = 1'b1;
    ram_we         = 1'b0;
    ram_waddr      = idx_r;
    ram_wdata      = ram_rdata;
    ram_raddr      = idx_r;

    unique case (state_r)
      iol_pkg::S_IDLE: begin
        if (start) begin
          val_nxt = in_val_kept;
          unique case (cmd)
            iol_pkg::CMD_PUSH_BACK, iol_pkg::CMD_PUSH_FRONT, iol_pkg::CMD_INSERT: begin
              if (full) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = iol_pkg::ST_FULL;
              end else if (cmd == iol_pkg::CMD_INSERT && pos_cmp > len_cmp) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = iol_pkg::ST_BAD_POS;
              end else begin
                idx_nxt   = length_r[ADDR_W-1:0];
                state_nxt = iol_pkg::S_INS;
                if (cmd == iol_pkg::CMD_PUSH_BACK) begin
                  pos_nxt = length_r[ADDR_W-1:0];
                end else if (cmd == iol_pkg::CMD_PUSH_FRONT) begin
                  pos_nxt = '0;
                end else begin
                  pos_nxt = in_position[ADDR_W-1:0];
                end
              end
            end
            iol_pkg::CMD_POP_FRONT, iol_pkg::CMD_POP_BACK, iol_pkg::CMD_ERASE: begin
              if (empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = iol_pkg::ST_EMPTY;
              end else if (cmd == iol_pkg::CMD_ERASE && pos_cmp >= len_cmp) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = iol_pkg::ST_BAD_POS;
              end else begin
                state_nxt = iol_pkg::S_ERS;
                if (cmd == iol_pkg::CMD_POP_BACK) begin
                  idx_nxt = ADDR_W'(length_r - LEN_W'(1));
                end else if (cmd == iol_pkg::CMD_POP_FRONT) begin
                  idx_nxt = '0;
                end else begin
                  idx_nxt = in_position[ADDR_W-1:0];
                end
              end
            end
            iol_pkg::CMD_DUMP: begin
              if (empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = iol_pkg::ST_EMPTY;
              end else begin
                idx_nxt   = '0;
                state_nxt = iol_pkg::S_DMP_RD;
              end
            end
            default: begin
              // unused code: no result
            end
          endcase
        end
      end

      // Insert: shift entries up until the target slot is free
      iol_pkg::S_INS: begin
        if (idx_r != pos_r) begin
          ram_raddr = idx_r - ADDR_W'(1);
          state_nxt = iol_pkg::S_INS_WR;
        end else begin
          ram_we        = 1'b1;
          ram_wdata     = val_r;
          length_nxt    = length_r + LEN_W'(1);
          out_valid_nxt = 1'b1;
          state_nxt     = iol_pkg::S_IDLE;
        end
      end

      iol_pkg::S_INS_WR: begin
        ram_we    = 1'b1;
        idx_nxt   = idx_r - ADDR_W'(1);
        state_nxt = iol_pkg::S_INS;
      end

      // Erase: pull entries down over the removed slot
      iol_pkg::S_ERS: begin
        if (idx_ext_inc < length_r) begin
          ram_raddr = idx_r + ADDR_W'(1);
          state_nxt = iol_pkg::S_ERS_WR;
        end else begin
          length_nxt    = length_r - LEN_W'(1);
          out_valid_nxt = 1'b1;
          state_nxt     = iol_pkg::S_IDLE;
        end
      end

      iol_pkg::S_ERS_WR: begin
        ram_we    = 1'b1;
        idx_nxt   = idx_r + ADDR_W'(1);
        state_nxt = iol_pkg::S_ERS;
      end

      // Dump: read one entry, send one beat
      iol_pkg::S_DMP_RD: begin
        state_nxt = iol_pkg::S_DMP_OUT;
      end

      iol_pkg::S_DMP_OUT: begin
        out_valid_nxt = 1'b1;
        out_elem_nxt  = rd_elem;
        out_has_nxt   = 1'b1;
        out_last_nxt  = (idx_ext_inc == length_r);
        if (idx_ext_inc == length_r) begin
          state_nxt = iol_pkg::S_IDLE;
        end else begin
          idx_nxt   = idx_r + ADDR_W'(1);
          state_nxt = iol_pkg::S_DMP_RD;
        end
      end

      default: begin
        state_nxt = iol_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= iol_pkg::S_IDLE;
      length_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      length_r    <= length_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    out_elem_r   <= out_elem_nxt;
    out_has_r    <= out_has_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_elem_out  = out_elem_r;
  assign out_has_value = out_has_r;
  assign out_status    = out_status_r;
  assign out_last      = out_last_r;

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for indexed_ordered_list: directed and random command beats,
// each result checked against an in-bench list model. Depends on iol_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;
  import iol_pkg::*;

  localparam int unsigned LIST_DEPTH = DEPTH_DEF;

  // One expected result beat
  typedef struct {
    logic [31:0] elem;
    logic        has;
    status_t     st;
    logic        last;
  } result_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [2:0]         in_command;
  logic [7:0]         in_position;
  logic signed [31:0] in_value;
  logic               out_valid;
  logic signed [31:0] out_elem_out;
  logic               out_has_value;
  logic [1:0]         out_status;
  logic               out_last;

  // Shadow copy of the list
  logic [31:0] list_cells [LIST_DEPTH];
  int unsigned list_len;

  result_t     pending_results[$];
  result_t     head_result;
  int unsigned error_count;
  bit          idle_on;
  int unsigned drain_cycles;

  indexed_ordered_list u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_command   (in_command),
    .in_position  (in_position),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_elem_out (out_elem_out),
    .out_has_value(out_has_value),
    .out_status   (out_status),
    .out_last     (out_last)
  );

  // 10 ns clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= 40) begin
      $display("mismatch at %0t ns: %s", $time, msg);
    end
  endtask

  // Insert into the shadow list; full is checked before the position
  function automatic status_t list_insert(input int unsigned pos, input logic [31:0] val);
    if (list_len >= LIST_DEPTH) return ST_FULL;
    if (pos > list_len) return ST_BAD_POS;
    for (int unsigned i = list_len; i > pos; i--) list_cells[i] = list_cells[i - 1];
    list_cells[pos] = val;
    list_len++;
    return ST_OK;
  endfunction

  // Remove from the shadow list; empty is checked before the position
  function automatic status_t list_remove(input int unsigned pos);
    if (list_len == 0) return ST_EMPTY;
    if (pos >= list_len) return ST_BAD_POS;
    for (int unsigned i = pos; i + 1 < list_len; i++) list_cells[i] = list_cells[i + 1];
    list_len--;
    return ST_OK;
  endfunction

  // Apply one accepted command beat and queue the result beats it causes
  function automatic void predict_list_results(input cmd_t cmd, input logic [7:0] pos,
                                               input logic [31:0] val);
    result_t r;
    r.elem = '0;
    r.has  = 1'b0;
    r.last = 1'b1;
    r.st   = ST_OK;
    case (cmd)
      CMD_PUSH_BACK:  r.st = list_insert(list_len, val);
      CMD_PUSH_FRONT: r.st = list_insert(0, val);
      CMD_POP_FRONT:  r.st = list_remove(0);
      CMD_POP_BACK:   r.st = (list_len == 0) ? ST_EMPTY : list_remove(list_len - 1);
      CMD_INSERT:     r.st = list_insert(pos, val);
      CMD_ERASE:      r.st = list_remove(pos);
      CMD_DUMP: begin
        if (list_len == 0) begin
          r.st = ST_EMPTY;
        end else begin
          for (int unsigned i = 0; i < list_len; i++) begin
            r.elem = list_cells[i];
            r.has  = 1'b1;
            r.last = (i + 1 == list_len);
            pending_results.insert(pending_results.size(), r);
          end
          return;
        end
      end
      default: return;  // unused code: no result
    endcase
    pending_results.insert(pending_results.size(), r);
  endfunction

  // Check result beats, then model any beat accepted at this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result beat elem=%h status=%0d",
                                    out_elem_out, out_status));
        end else begin
          head_result = pending_results[0];
          pending_results.delete(0);
          if (out_elem_out !== head_result.elem)
            report_mismatch($sformatf("elem_out got %h want %h", out_elem_out,
                                      head_result.elem));
          if (out_has_value !== head_result.has)
            report_mismatch($sformatf("has_value got %b want %b", out_has_value,
                                      head_result.has));
          if (out_status !== head_result.st)
            report_mismatch($sformatf("status got %0d want %0d", out_status,
                                      head_result.st));
          if (out_last !== head_result.last)
            report_mismatch($sformatf("last got %b want %b", out_last, head_result.last));
        end
      end
      if (start && !busy) begin
        predict_list_results(cmd_t'(in_command), in_position, in_value);
      end
    end
  end

  // Send one command beat; called and returning at a falling edge
  task automatic send_command(input cmd_t cmd, input logic [7:0] pos, input logic [31:0] val);
    if (idle_on) begin
      while ($urandom_range(99) < 38) @(negedge clk);
    end
    in_command  = cmd;
    in_position = pos;
    in_value    = val;
    start       = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    start = 1'b0;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Mostly in-range positions, some anywhere in the 8-bit field
  function automatic logic [7:0] pick_position(input cmd_t cmd);
    if ($urandom_range(9) < 3) return 8'($urandom_range(255));
    if (cmd == CMD_INSERT) return 8'($urandom_range(list_len));
    if (list_len == 0) return 8'd0;
    return 8'($urandom_range(list_len - 1));
  endfunction

  // Growing mix favors pushes and inserts, shrinking mix favors pops and erases
  function automatic cmd_t pick_command(input bit grow);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 20) return grow ? CMD_PUSH_BACK : CMD_POP_FRONT;
    if (r < 38) return grow ? CMD_PUSH_FRONT : CMD_POP_BACK;
    if (r < 58) return grow ? CMD_INSERT : CMD_ERASE;
    if (r < 66) return grow ? CMD_POP_FRONT : CMD_PUSH_BACK;
    if (r < 74) return grow ? CMD_POP_BACK : CMD_PUSH_FRONT;
    if (r < 80) return grow ? CMD_ERASE : CMD_INSERT;
    if (r < 96) return CMD_DUMP;
    return CMD_NONE;
  endfunction

  task automatic send_random(input bit grow);
    cmd_t cmd;
    cmd = pick_command(grow);
    send_command(cmd, pick_position(cmd), pick_value());
  endtask

  // Removal, dump, unused and out-of-range insert commands on an empty list
  task automatic test_empty_list();
    send_command(CMD_DUMP, 8'd0, 32'd0);
    send_command(CMD_POP_FRONT, 8'd0, 32'd0);
    send_command(CMD_POP_BACK, 8'd0, 32'd0);
    send_command(CMD_ERASE, 8'd0, 32'd0);
    send_command(CMD_ERASE, 8'd255, 32'd0);
    send_command(CMD_NONE, 8'd0, 32'h1234_5678);
    send_command(CMD_INSERT, 8'd1, 32'h5555_5555);
  endtask

  // Value extremes, inserts at both ends and middle, out-of-range positions
  task automatic test_edges();
    send_command(CMD_PUSH_BACK, 8'd0, 32'h7fff_ffff);
    send_command(CMD_PUSH_FRONT, 8'd0, 32'h8000_0000);
    send_command(CMD_INSERT, 8'd2, 32'hffff_ffff);
    send_command(CMD_INSERT, 8'd1, 32'h0000_0000);
    send_command(CMD_INSERT, 8'd255, 32'haaaa_aaaa);
    send_command(CMD_ERASE, 8'd4, 32'd0);
    send_command(CMD_ERASE, 8'd255, 32'd0);
    send_command(CMD_DUMP, 8'd0, 32'd0);
    send_command(CMD_ERASE, 8'd1, 32'd0);
    send_command(CMD_POP_FRONT, 8'd0, 32'd0);
    send_command(CMD_POP_BACK, 8'd0, 32'd0);
    send_command(CMD_DUMP, 8'd0, 32'd0);
    send_command(CMD_ERASE, 8'd0, 32'd0);
    send_command(CMD_DUMP, 8'd0, 32'd0);
  endtask

  // Fill to capacity with random content, hit it while full, then drain
  task automatic test_fill_and_drain();
    cmd_t cmd;
    repeat (3) begin
      while (list_len < LIST_DEPTH) begin
        case ($urandom_range(2))
          0:       cmd = CMD_PUSH_BACK;
          1:       cmd = CMD_PUSH_FRONT;
          default: cmd = CMD_INSERT;
        endcase
        send_command(cmd, 8'($urandom_range(list_len)), pick_value());
      end
      send_command(CMD_PUSH_BACK, 8'd0, pick_value());
      send_command(CMD_PUSH_FRONT, 8'd0, pick_value());
      send_command(CMD_INSERT, 8'($urandom_range(255)), pick_value());
      send_command(CMD_INSERT, 8'd0, pick_value());
      send_command(CMD_DUMP, 8'd0, 32'd0);
      while (list_len > 0) begin
        case ($urandom_range(2))
          0:       cmd = CMD_POP_FRONT;
          1:       cmd = CMD_POP_BACK;
          default: cmd = CMD_ERASE;
        endcase
        send_command(cmd, 8'($urandom_range(list_len - 1)), pick_value());
      end
      send_command(CMD_POP_BACK, 8'd0, 32'd0);
      send_command(CMD_DUMP, 8'd0, 32'd0);
    end
  endtask

  // Random mix, alternating growth and shrink phases; no idling in the middle
  task automatic test_random_mix();
    for (int unsigned n = 0; n < 180; n++) begin
      idle_on = !(n >= 60 && n < 110);
      send_random((n / 30) % 2 == 0);
    end
    idle_on = 1'b1;
  endtask

  initial begin
    error_count = 0;
    idle_on     = 1'b1;
    list_len    = 0;
    start       = 1'b0;
    in_command  = CMD_NONE;
    in_position = '0;
    in_value    = '0;
    rst_n       = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_list();
    test_edges();
    test_fill_and_drain();
    test_random_mix();

    // Drain outstanding results, then allow for the longest operation
    drain_cycles = 0;
    while (pending_results.size() != 0 && drain_cycles < 2000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (40) @(posedge clk);
    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived",
                                pending_results.size()));
    end

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
